### rtl/bht_pkg.sv
// bht_pkg: types and constants shared by the button hold tracker files.
// No dependencies.
package bht_pkg;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic       KIND_SAMPLE = 1'b0;
    localparam logic       KIND_QUERY  = 1'b1;

    localparam logic [1:0] DEV_KEY   = 2'd0;
    localparam logic [1:0] DEV_MOUSE = 2'd1;
    localparam logic [1:0] DEV_JOY   = 2'd2;

    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_DEV_MASK  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [1:0] device;
        logic [7:0] code;
        logic       pressed;
    } in_t;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] last_count;
        logic        is_down;
        logic        just_pressed;
        logic        just_released;
        logic        is_held;
        logic        has_changed;
    } out_t;

    typedef struct packed {
        logic        block_enabled;
        logic [2:0]  device_mask;
        logic [15:0] hold_threshold;
    } cfg_t;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] last;
    } entry_t;

endpackage

### rtl/bht_store.sv
// bht_store: single-port-write, registered-read table of count/last pairs.
// Depends on bht_pkg for entry_t.
module bht_store
    import bht_pkg::*;
#(
    parameter int DEPTH = 264
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/bht_eval.sv
// bht_eval: counter update, query gating and result flags for one entry.
// Depends on bht_pkg for in_t, out_t, cfg_t and entry_t.
module bht_eval
    import bht_pkg::*;
(
    input  in_t    item,
    input  logic   hit,
    input  entry_t rd_entry,
    input  cfg_t   cfg,
    output out_t   result,
    output logic   wr_en,
    output entry_t wr_entry
);

    function automatic out_t make_result(logic [15:0] cnt, logic [15:0] lst,
                                         logic [15:0] thr);
        out_t r;
        r.count         = cnt;
        r.last_count    = lst;
        r.is_down       = (cnt != 16'd0);
        r.just_pressed  = (cnt == 16'd1);
        r.just_released = (cnt != lst) && (cnt == 16'd0);
        r.is_held       = (cnt > thr);
        r.has_changed   = (cnt != lst);
        return r;
    endfunction

    logic [15:0] nxt;
    logic        mask_ok;
    logic        query_ok;

    always_comb begin
        if (!item.pressed) begin
            nxt = 16'd0;
        end else if (rd_entry.count == COUNT_MAX) begin
            nxt = COUNT_MAX;
        end else begin
            nxt = rd_entry.count + 16'd1;
        end
    end

    assign mask_ok  = (item.device == DEV_KEY) ? cfg.device_mask[0] : cfg.device_mask[1];
    assign query_ok = cfg.block_enabled && mask_ok && (item.code != 8'd0);

    always_comb begin
        result         = '0;
        wr_en          = 1'b0;
        wr_entry.count = nxt;
        wr_entry.last  = rd_entry.count;
        if (hit) begin
            if (item.kind == KIND_SAMPLE) begin
                wr_en  = 1'b1;
                result = make_result(nxt, rd_entry.count, cfg.hold_threshold);
            end else if (query_ok) begin
                result = make_result(rd_entry.count, rd_entry.last, cfg.hold_threshold);
            end
        end
    end

endmodule

### rtl/button_hold_tracker.sv
// button_hold_tracker: per-button saturating hold counters in one table.
// A request is registered with its table read; in ST_READ the result is then registered
// to m_data. No new request is taken before ST_READ ends or while a result is stalled.
// Reset: synchronous, active low; then a clearing pass over all KEY_SLOTS + MOUSE_SLOTS
// entries with s_ready low; configuration writes are taken throughout.
// Depends on bht_pkg, bht_store and bht_eval.
module button_hold_tracker
    import bht_pkg::*;
#(
    parameter int KEY_SLOTS   = 256,
    parameter int MOUSE_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int DEPTH = KEY_SLOTS + MOUSE_SLOTS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    cfg_t            cfg_reg;
    in_t             item_reg;
    logic            hit_reg;
    logic [AW-1:0]   addr_reg;
    logic            m_valid_reg;
    out_t            m_data_reg;

    logic            accept;
    logic            key_hit, mouse_hit;
    logic [AW-1:0]   addr_in;
    entry_t          rd_entry;
    out_t            result;
    logic            eval_wr_en;
    entry_t          eval_wr_entry;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign key_hit   = (s_data.device == DEV_KEY) && (int'(s_data.code) < KEY_SLOTS);
    assign mouse_hit = (s_data.device == DEV_MOUSE) && (int'(s_data.code) < MOUSE_SLOTS);
    assign addr_in   = (s_data.device == DEV_KEY) ? AW'(s_data.code)
                                                  : AW'(KEY_SLOTS + int'(s_data.code));

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (state_reg == ST_READ) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_enabled  <= 1'b1;
            cfg_reg.device_mask    <= 3'b111;
            cfg_reg.hold_threshold <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ENABLE:    cfg_reg.block_enabled  <= cfg_wdata[0];
                REG_DEV_MASK:  cfg_reg.device_mask    <= cfg_wdata[2:0];
                REG_THRESHOLD: cfg_reg.hold_threshold <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
            hit_reg  <= key_hit || mouse_hit;
            addr_reg <= addr_in;
        end
        if (state_reg == ST_READ) begin
            m_data_reg <= result;
        end
    end

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end else begin
            wr_en   = (state_reg == ST_READ) && eval_wr_en;
            wr_addr = addr_reg;
            wr_data = eval_wr_entry;
        end
    end

    bht_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (addr_in),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bht_eval u_eval (
        .item     (item_reg),
        .hit      (hit_reg),
        .rd_entry (rd_entry),
        .cfg      (cfg_reg),
        .result   (result),
        .wr_en    (eval_wr_en),
        .wr_entry (eval_wr_entry)
    );

endmodule

### rtl/bht_checker.sv
// bht_checker: port-level assertions on the result channel, bound to the top level.
// Depends on bht_pkg and button_hold_tracker.
module bht_checker
    import bht_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_down: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_down == (m_data.count != 16'd0)))
        else $error("is_down disagrees with count");

    a_changed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.has_changed == (m_data.count != m_data.last_count)))
        else $error("has_changed disagrees with counts");

    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.just_released == (m_data.has_changed && !m_data.is_down)))
        else $error("just_released inconsistent");

endmodule

bind button_hold_tracker bht_checker u_bht_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
